### rtl/lttb_pkg.sv
// Package with the types, constants and state codes of the LTTB downsampler.
package lttb_pkg;

    localparam int COORD_W     = 24;
    localparam int COUNT_W     = 20;
    localparam int MAX_BUCKET  = 1024;
    localparam int SLOT_W      = $clog2(MAX_BUCKET);
    localparam int FILL_W      = SLOT_W + 1;
    localparam int STORE_DEPTH = 2 * MAX_BUCKET;
    localparam int ADDR_W      = SLOT_W + 1;
    localparam int SUM_W       = COORD_W + FILL_W - 1;
    localparam int DIFF_W      = SUM_W + 3;
    localparam int DELTA_W     = COORD_W + 1;
    localparam int PROD_W      = DIFF_W + DELTA_W;
    localparam int AREA_W      = PROD_W - 1;
    localparam int PADDR_W     = 3;
    localparam int PDATA_W     = 32;
    localparam int CNT_W       = $clog2(COUNT_W + 1);

    localparam logic REG_POINT_COUNT   = 1'b0;
    localparam logic REG_TARGET_POINTS = 1'b1;

    typedef struct packed {
        logic signed [COORD_W-1:0] x_value;
        logic signed [COORD_W-1:0] y_value;
    } t_in_item;

    typedef struct packed {
        logic signed [COORD_W-1:0] out_x;
        logic signed [COORD_W-1:0] out_y;
        logic [COUNT_W-1:0]        source_index;
        logic                      series_end;
        logic                      bucket_too_large;
    } t_out_item;

    typedef struct packed {
        logic               start;
        logic [COUNT_W-1:0] dividend;
        logic [COUNT_W-1:0] divisor;
    } t_div_req;

    typedef struct packed {
        logic               done;
        logic [COUNT_W-1:0] quotient;
        logic [COUNT_W-1:0] remainder;
    } t_div_rsp;

    typedef enum logic [3:0] {
        S_IDLE,
        S_DISPATCH,
        S_DIV_START,
        S_DIV_WAIT,
        S_STORE,
        S_LEN_X,
        S_LEN_Y,
        S_READ,
        S_PROD1,
        S_PROD2,
        S_COMPARE,
        S_PICK,
        S_PICK_WAIT,
        S_FINAL,
        S_EMIT
    } t_state;

endpackage

### rtl/lttb_div.sv
// Restoring divider that yields the quotient and remainder one bit per cycle.
module lttb_div
    import lttb_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  t_div_req i_req,
    output t_div_rsp o_rsp
);

    logic [COUNT_W:0]   r_rem;
    logic [COUNT_W-1:0] r_quo;
    logic [COUNT_W-1:0] r_dsr;
    logic [CNT_W-1:0]   r_cnt;
    logic               r_busy;
    logic               r_done;
    logic [COUNT_W:0]   shifted;

    assign shifted = {r_rem[COUNT_W-1:0], r_quo[COUNT_W-1]};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= CNT_W'(COUNT_W);
                r_rem  <= '0;
                r_quo  <= i_req.dividend;
                r_dsr  <= i_req.divisor;
            end else if (r_busy) begin
                if (shifted >= {1'b0, r_dsr}) begin
                    r_rem <= shifted - {1'b0, r_dsr};
                    r_quo <= {r_quo[COUNT_W-2:0], 1'b1};
                end else begin
                    r_rem <= shifted;
                    r_quo <= {r_quo[COUNT_W-2:0], 1'b0};
                end
                r_cnt <= r_cnt - CNT_W'(1);
                if (r_cnt == CNT_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_rsp.done      = r_done;
    assign o_rsp.quotient  = r_quo;
    assign o_rsp.remainder = r_rem[COUNT_W-1:0];

endmodule

### rtl/lttb_downsampler.sv
// LTTB downsampler top level: one point is taken per transaction and only the kept
// points leave. In pass-through, tiny-target and oversized-bucket modes no triangle
// scan is run. When downsampling, the first point of a series waits for the
// bucket-step divider, and the point that closes a bucket also runs the triangle scan
// of the previous bucket through one shared multiplier and the registered bucket
// store, each stored point passing through a first product, a second product and a
// compare. A kept point can also wait while the output register still holds an
// untaken transaction.
module lttb_downsampler
    import lttb_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  t_in_item           i_in_data,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output t_out_item          o_out_data,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [PDATA_W-1:0] pwdata,
    output logic [PDATA_W-1:0] prdata,
    output logic               pready
);

    t_state r_state, n_state, r_ret;

    logic [COUNT_W-1:0] r_cfg_n, r_cfg_t;
    t_in_item           r_in;
    logic [COUNT_W-1:0] r_count, r_bucket, r_q, r_r, r_q0, r_r0;
    logic [FILL_W-1:0]  r_fill, r_scan, r_k, r_slot;
    logic               r_bank, r_fb;
    logic signed [SUM_W-1:0]   r_sum_x, r_sum_y;
    logic signed [COORD_W-1:0] r_ax, r_ay, r_bx;
    logic signed [DIFF_W-1:0]  r_dxa, r_dya;
    logic signed [PROD_W-1:0]  r_prod, r_p1;
    logic [AREA_W-1:0]  r_best;
    t_out_item          r_pend, r_out;
    logic               r_oval;

    t_in_item           r_mem [STORE_DEPTH];
    t_in_item           r_rdata;
    logic [ADDR_W-1:0]  rd_addr;
    logic               mem_we;

    logic signed [DIFF_W-1:0]  mul_a;
    logic signed [DELTA_W-1:0] mul_b;
    logic signed [PROD_W-1:0]  mul_p;
    logic signed [PROD_W-1:0]  diff;
    logic [AREA_W-1:0]         area;

    t_div_req div_req;
    t_div_rsp div_rsp;

    logic               cfg_wr, accept, out_free;
    logic [COUNT_W-1:0] n_eff, d_val, m_val;
    logic               mode_pass, mode_tiny, last;
    logic [COUNT_W:0]   end_pos, ceil_q;
    logic [FILL_W-1:0]  lim, k_next;
    logic               better;

    assign cfg_wr    = psel && penable && pwrite;
    assign pready    = 1'b1;
    assign prdata    = (paddr[2] == REG_TARGET_POINTS) ? PDATA_W'(r_cfg_t) : PDATA_W'(r_cfg_n);
    assign accept    = i_in_valid && o_in_ready;
    assign out_free  = !r_oval || i_out_ready;

    assign n_eff     = (r_cfg_n == '0) ? COUNT_W'(1) : r_cfg_n;
    assign mode_pass = (r_cfg_t == '0) || (r_cfg_t >= n_eff);
    assign mode_tiny = r_cfg_t <= COUNT_W'(2);
    assign d_val     = r_cfg_t - COUNT_W'(2);
    assign m_val     = n_eff - COUNT_W'(2);
    assign last      = ({1'b0, r_count} + (COUNT_W+1)'(1)) >= {1'b0, n_eff};
    assign end_pos   = (({1'b0, r_q} + (COUNT_W+1)'(1)) > {1'b0, n_eff}) ?
                       {1'b0, n_eff} : ({1'b0, r_q} + (COUNT_W+1)'(1));
    assign ceil_q    = {1'b0, div_rsp.quotient} + (COUNT_W+1)'(div_rsp.remainder != '0);
    assign lim       = (r_scan > FILL_W'(MAX_BUCKET)) ? FILL_W'(MAX_BUCKET) : r_scan;
    assign k_next    = r_k + FILL_W'(1);

    assign mul_p  = PROD_W'(mul_a) * PROD_W'(mul_b);
    assign diff   = r_p1 - r_prod;
    assign area   = diff[PROD_W-1] ? AREA_W'(-diff) : diff[AREA_W-1:0];
    assign better = (r_k == '0) || (area > r_best);

    lttb_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (div_req),
        .o_rsp   (div_rsp)
    );

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE:      if (i_in_valid) n_state = S_DISPATCH;
            S_DISPATCH: begin
                priority if (mode_pass || (r_fb && r_count != '0)) n_state = S_EMIT;
                else if (mode_tiny) n_state = (r_count == '0 || last) ? S_EMIT : S_IDLE;
                else if (r_count == '0) n_state = S_DIV_START;
                else n_state = S_STORE;
            end
            S_DIV_START: n_state = S_DIV_WAIT;
            S_DIV_WAIT:  if (div_rsp.done) n_state = S_EMIT;
            S_STORE: begin
                priority if (({1'b0, r_count} + (COUNT_W+1)'(1)) < end_pos) n_state = S_IDLE;
                else if (r_bucket != '0 && r_scan != '0) n_state = S_LEN_X;
                else n_state = S_FINAL;
            end
            S_LEN_X:     n_state = S_LEN_Y;
            S_LEN_Y:     n_state = S_READ;
            S_READ:      n_state = S_PROD1;
            S_PROD1:     n_state = S_PROD2;
            S_PROD2:     n_state = S_COMPARE;
            S_COMPARE:   n_state = (k_next < lim) ? S_PROD1 : S_PICK;
            S_PICK:      n_state = S_PICK_WAIT;
            S_PICK_WAIT: n_state = S_EMIT;
            S_FINAL:     n_state = (r_bucket >= d_val || last) ? S_EMIT : S_IDLE;
            S_EMIT:      if (out_free) n_state = r_ret;
            default:     n_state = S_IDLE;
        endcase
    end

    always_comb begin
        o_in_ready       = r_state == S_IDLE;
        div_req.start    = r_state == S_DIV_START;
        div_req.dividend = m_val;
        div_req.divisor  = d_val;
        mem_we           = (r_state == S_STORE) && (r_fill < FILL_W'(MAX_BUCKET));
        mul_a            = '0;
        mul_b            = '0;
        rd_addr          = {~r_bank, SLOT_W'(0)};
        unique case (r_state)
            S_LEN_X: begin
                mul_a = DIFF_W'(r_fill);
                mul_b = DELTA_W'(r_ax);
            end
            S_LEN_Y: begin
                mul_a = DIFF_W'(r_fill);
                mul_b = DELTA_W'(r_ay);
            end
            S_PROD1: begin
                mul_a = r_dxa;
                mul_b = DELTA_W'(r_rdata.y_value) - DELTA_W'(r_ay);
            end
            S_PROD2: begin
                mul_a = r_dya;
                mul_b = DELTA_W'(r_ax) - DELTA_W'(r_bx);
            end
            S_COMPARE: rd_addr = {~r_bank, k_next[SLOT_W-1:0]};
            S_PICK:    rd_addr = {~r_bank, r_slot[SLOT_W-1:0]};
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[{r_bank, r_fill[SLOT_W-1:0]}] <= r_in;
        end
        r_rdata <= r_mem[rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_ret    <= S_IDLE;
            r_cfg_n  <= COUNT_W'(1);
            r_cfg_t  <= '0;
            r_count  <= '0;
            r_fill   <= '0;
            r_scan   <= '0;
            r_bank   <= 1'b0;
            r_bucket <= '0;
            r_fb     <= 1'b0;
            r_oval   <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_state == S_EMIT && out_free) r_oval <= 1'b1;
            else if (r_oval && i_out_ready) r_oval <= 1'b0;
            unique case (r_state)
                S_IDLE: if (i_in_valid) r_in <= i_in_data;
                S_DISPATCH: begin
                    r_ret <= S_IDLE;
                    r_pend.out_x        <= r_in.x_value;
                    r_pend.out_y        <= r_in.y_value;
                    r_pend.source_index <= r_count;
                    r_pend.series_end   <= last;
                    r_pend.bucket_too_large <= !mode_pass && r_fb;
                    if (mode_pass || mode_tiny || (r_fb && r_count != '0)) begin
                        r_count <= last ? '0 : r_count + COUNT_W'(1);
                    end
                end
                S_DIV_WAIT: if (div_rsp.done) begin
                    r_count <= COUNT_W'(1);
                    r_pend.source_index <= '0;
                    r_pend.series_end   <= 1'b0;
                    if (ceil_q > (COUNT_W+1)'(MAX_BUCKET)) begin
                        r_fb <= 1'b1;
                        r_pend.bucket_too_large <= 1'b1;
                    end else begin
                        r_fb     <= 1'b0;
                        r_pend.bucket_too_large <= 1'b0;
                        r_bank   <= 1'b0;
                        r_sum_x  <= '0;
                        r_sum_y  <= '0;
                        r_bucket <= '0;
                        r_fill   <= '0;
                        r_scan   <= '0;
                        r_slot   <= '0;
                        r_best   <= '0;
                        r_ax     <= r_in.x_value;
                        r_ay     <= r_in.y_value;
                        r_q      <= div_rsp.quotient;
                        r_r      <= div_rsp.remainder;
                        r_q0     <= div_rsp.quotient;
                        r_r0     <= div_rsp.remainder;
                    end
                end
                S_STORE: begin
                    r_sum_x <= r_sum_x + SUM_W'(r_in.x_value);
                    r_sum_y <= r_sum_y + SUM_W'(r_in.y_value);
                    r_fill  <= r_fill + FILL_W'(1);
                    if (({1'b0, r_count} + (COUNT_W+1)'(1)) < end_pos) begin
                        r_count <= r_count + COUNT_W'(1);
                    end
                end
                S_LEN_X: r_prod <= mul_p;
                S_LEN_Y: begin
                    r_dxa  <= r_prod[DIFF_W-1:0] - DIFF_W'(r_sum_x);
                    r_prod <= mul_p;
                    r_k    <= '0;
                end
                S_READ: r_dya <= DIFF_W'(r_sum_y) - r_prod[DIFF_W-1:0];
                S_PROD1: begin
                    r_bx   <= r_rdata.x_value;
                    r_prod <= mul_p;
                end
                S_PROD2: begin
                    r_p1   <= r_prod;
                    r_prod <= mul_p;
                end
                S_COMPARE: begin
                    if (better) begin
                        r_best <= area;
                        r_slot <= r_k;
                    end
                    r_k <= k_next;
                end
                S_PICK_WAIT: begin
                    r_ax  <= r_rdata.x_value;
                    r_ay  <= r_rdata.y_value;
                    r_ret <= S_FINAL;
                    r_pend.out_x <= r_rdata.x_value;
                    r_pend.out_y <= r_rdata.y_value;
                    r_pend.source_index <= r_count + COUNT_W'(1) - COUNT_W'(r_fill)
                                           - COUNT_W'(r_scan) + COUNT_W'(r_slot);
                    r_pend.series_end <= 1'b0;
                    r_pend.bucket_too_large <= 1'b0;
                end
                S_FINAL: begin
                    r_ret <= S_IDLE;
                    if (r_bucket >= d_val || last) begin
                        r_count <= '0;
                        r_pend.out_x <= r_in.x_value;
                        r_pend.out_y <= r_in.y_value;
                        r_pend.source_index <= r_count;
                        r_pend.series_end <= 1'b1;
                        r_pend.bucket_too_large <= 1'b0;
                    end else begin
                        r_count  <= r_count + COUNT_W'(1);
                        r_scan   <= r_fill;
                        r_fill   <= '0;
                        r_sum_x  <= '0;
                        r_sum_y  <= '0;
                        r_bank   <= ~r_bank;
                        r_bucket <= r_bucket + COUNT_W'(1);
                        if (({1'b0, r_r} + {1'b0, r_r0}) >= {1'b0, d_val}) begin
                            r_r <= r_r + r_r0 - d_val;
                            r_q <= r_q + r_q0 + COUNT_W'(1);
                        end else begin
                            r_r <= r_r + r_r0;
                            r_q <= r_q + r_q0;
                        end
                    end
                end
                S_EMIT: if (out_free) begin
                    r_out  <= r_pend;
                end
                default: begin
                end
            endcase
            if (cfg_wr) begin
                if (paddr[2] == REG_TARGET_POINTS) r_cfg_t <= pwdata[COUNT_W-1:0];
                else r_cfg_n <= pwdata[COUNT_W-1:0];
                r_count  <= '0;
                r_fill   <= '0;
                r_scan   <= '0;
                r_bank   <= 1'b0;
                r_bucket <= '0;
                r_fb     <= 1'b0;
            end
        end
    end

    assign o_out_valid = r_oval;
    assign o_out_data  = r_out;

    a_fill_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fill <= FILL_W'(MAX_BUCKET))
        else $error("bucket fill count ran past the store size");

    a_div_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_rsp.done |-> r_state == S_DIV_WAIT)
        else $error("divider finished outside of its wait state");

    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> !o_in_ready)
        else $error("input ready right after a transaction was accepted");

    a_emit_loads: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_EMIT && out_free) |=> r_oval)
        else $error("emit state left without loading the output register");

endmodule
